[sv/b64e_pkg.sv]
// Shared types, constants and the base64 alphabet function for the line-wrapped encoder.
package b64e_pkg;

    // Input item modes.
    localparam logic MODE_DATA  = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // Configuration register indexes.
    localparam logic [0:0] CFG_QUADS_PER_LINE = 1'b0;
    localparam logic [0:0] CFG_LINE_END_CHAR  = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [5:0] C_RST_QUADS_PER_LINE = 6'd19;
    localparam logic [7:0] C_RST_LINE_END_CHAR  = 8'd13;

    // Fixed characters.
    localparam logic [7:0] C_PAD_CHAR   = 8'h3D;
    localparam logic [7:0] C_CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] C_CHAR_SLASH = 8'h2F;

    // Bytes already taken of the current three-byte group.
    typedef enum logic [1:0] {
        PH_ZERO = 2'd0,
        PH_ONE  = 2'd1,
        PH_TWO  = 2'd2
    } t_phase;

    // Characters produced by one input item, emitted from index 0 upward.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [2:0]      count;
    } t_job;

    // Map a six-bit value onto the standard base64 alphabet.
    function automatic logic [7:0] f_sextet(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return w + 8'h41;
        end else if (v < 6'd52) begin
            return w + 8'h47;
        end else if (v < 6'd62) begin
            return w - 8'd4;
        end else if (v == 6'd62) begin
            return C_CHAR_PLUS;
        end else begin
            return C_CHAR_SLASH;
        end
    endfunction

endpackage

[sv/b64e_intf.sv]
// Valid/ready channel interfaces for message bytes in and characters out.
interface b64e_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface b64e_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;

    modport source (output valid, output out_char, output last_of_run, input ready);
    modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

[sv/b64e_front.sv]
// Front end: takes message items, tracks group and line state, builds character jobs.
module b64e_front import b64e_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [5:0] i_quads_per_line,
    input  logic [7:0] i_line_end_char,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_mode,
    input  logic [7:0] i_data_byte,
    output logic       o_job_valid,
    output t_job       o_job,
    input  logic       i_job_ready
);

    t_phase     r_phase, n_phase;
    logic [3:0] r_carry, n_carry;
    logic [5:0] r_groups, n_groups;
    logic [5:0] w_groups_inc;
    logic       w_accept;
    t_job       w_job;

    // An item is taken whenever the queue has room for its job.
    assign o_in_ready   = i_job_ready;
    assign w_accept     = i_in_valid && i_job_ready;
    assign w_groups_inc = r_groups + 6'd1;

    // Next group phase.
    always_comb begin
        if (i_mode == MODE_FLUSH) begin
            n_phase = PH_ZERO;
        end else begin
            unique case (r_phase)
                PH_ONE:  n_phase = PH_TWO;
                PH_TWO:  n_phase = PH_ZERO;
                default: n_phase = PH_ONE;
            endcase
        end
    end

    // Characters of this item, plus the carried bits and line count it leaves.
    always_comb begin
        w_job    = '0;
        n_carry  = r_carry;
        n_groups = r_groups;
        if (i_mode == MODE_DATA) begin
            unique case (r_phase)
                PH_ONE: begin
                    w_job.chars[0] = f_sextet({r_carry[1:0], i_data_byte[7:4]});
                    w_job.count    = 3'd1;
                    n_carry        = i_data_byte[3:0];
                end
                PH_TWO: begin
                    w_job.chars[0] = f_sextet({r_carry, i_data_byte[7:6]});
                    w_job.chars[1] = f_sextet(i_data_byte[5:0]);
                    n_carry        = 4'd0;
                    if (w_groups_inc == i_quads_per_line) begin
                        w_job.chars[2] = i_line_end_char;
                        w_job.count    = 3'd3;
                        n_groups       = 6'd0;
                    end else begin
                        w_job.count    = 3'd2;
                        n_groups       = w_groups_inc;
                    end
                end
                default: begin
                    w_job.chars[0] = f_sextet(i_data_byte[7:2]);
                    w_job.count    = 3'd1;
                    n_carry        = {2'b00, i_data_byte[1:0]};
                end
            endcase
        end else begin
            unique case (r_phase)
                PH_ONE: begin
                    w_job.chars[0] = f_sextet({r_carry[1:0], 4'b0000});
                    w_job.chars[1] = C_PAD_CHAR;
                    w_job.chars[2] = C_PAD_CHAR;
                    w_job.chars[3] = i_line_end_char;
                    w_job.count    = 3'd4;
                end
                PH_TWO: begin
                    w_job.chars[0] = f_sextet({r_carry, 2'b00});
                    w_job.chars[1] = C_PAD_CHAR;
                    w_job.chars[2] = i_line_end_char;
                    w_job.count    = 3'd3;
                end
                default: begin
                    // An open line still needs its terminator.
                    if (r_groups != 6'd0) begin
                        w_job.chars[0] = i_line_end_char;
                        w_job.count    = 3'd1;
                    end
                end
            endcase
            n_carry  = 4'd0;
            n_groups = 6'd0;
        end
    end

    // An item that gives no character pushes nothing.
    assign o_job_valid = i_in_valid && (w_job.count != 3'd0);
    assign o_job       = w_job;

    // Encoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_ZERO;
            r_carry  <= 4'd0;
            r_groups <= 6'd0;
        end else if (w_accept) begin
            r_phase  <= n_phase;
            r_carry  <= n_carry;
            r_groups <= n_groups;
        end
    end

    // A flush always leaves the encoder at the start of a fresh message.
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_mode == MODE_FLUSH) |=>
            (r_phase == PH_ZERO && r_carry == 4'd0 && r_groups == 6'd0))
        else $error("flush did not return the encoder to its start state");

endmodule

[sv/b64e_fifo.sv]
// Short job queue between the front end and the character sequencer.
module b64e_fifo import b64e_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_job i_in_job,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_job o_out_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push, w_pop;

    assign o_in_ready  = (r_count != CW'(DEPTH));
    assign o_out_valid = (r_count != CW'(0));
    assign o_out_job   = r_mem[r_rd_ptr];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_out_valid && i_out_ready;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_in_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // The fill count tracks transfers on both sides.
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count did not grow on a lone push");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("queue count did not shrink on a lone pop");

endmodule

[sv/b64e_back.sv]
// Back end: walks each job one character per cycle, while the output is free, into a registered output.
module b64e_back import b64e_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    output logic       o_job_ready,
    input  t_job       i_job,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_char,
    output logic       o_last_of_run
);

    t_job       r_job, n_job;
    logic       r_busy, n_busy;
    logic [1:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_char, n_out_char;
    logic       r_out_last, n_out_last;
    logic       w_out_free;
    logic       w_last_char;
    logic       w_send;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_last_char = ({1'b0, r_idx} == (r_job.count - 3'd1));
    assign w_send      = w_out_free && r_busy;
    assign o_job_ready = !r_busy || (w_send && w_last_char);

    // Next job, position and output register contents.
    always_comb begin
        n_job       = r_job;
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        if (w_out_free) begin
            n_out_valid = r_busy;
        end
        if (w_send) begin
            n_out_char = r_job.chars[r_idx];
            n_out_last = w_last_char;
            n_idx      = r_idx + 2'd1;
            if (w_last_char) begin
                n_busy = 1'b0;
            end
        end
        if (i_job_valid && o_job_ready) begin
            n_job  = i_job;
            n_busy = 1'b1;
            n_idx  = 2'd0;
        end
    end

    // Control state is reset; the job and character registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_char    = r_out_char;
    assign o_last_of_run = r_out_last;

    // A job in progress never points past its last character.
    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_job.count != 3'd0 && {1'b0, r_idx} < r_job.count))
        else $error("sequencer index outside the current job");

    // Finishing a job with no new one waiting leaves the sequencer idle.
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_send && w_last_char && !i_job_valid) |=> !r_busy)
        else $error("sequencer stayed busy after its last character");

endmodule

[sv/base64_encoder_line_wrapped.sv]
// Top level of the streaming base64 encoder with line wrapping.
//
// Input channel i_in carries one item per transfer: mode 0 is a message byte,
// mode 1 ends the message and flushes a partial group with '=' padding plus a
// final line end when the line holds characters. Output channel o_out carries
// one character per transfer; last_of_run marks the last character caused by
// an input item. An item that causes no character gives no transfer.
// Configuration is written through i_cfg_wr_en, i_cfg_index and i_cfg_wdata:
// index 0 sets the groups per line, index 1 the line end byte.
// The front end classifies each item in the cycle it is taken and pushes a job
// of one to four characters into a short queue. The back end emits one
// character per cycle while the receiver takes them; a job passes from the
// queue into the job register and then, character by character, into the
// output register. A new input item can be taken every cycle while the queue
// has room; throughput is set by the output register, with no gap between
// jobs: four characters per three data bytes plus one per line end.
// Reset restores the register defaults (19 groups, carriage return) and starts
// a fresh message. When the receiver stalls, the output register holds its
// character, the queue fills, and then input ready drops.
module base64_encoder_line_wrapped import b64e_pkg::*; #(
    parameter int P_QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_wdata,
    b64e_in_if.sink     i_in,
    b64e_out_if.source  o_out
);

    logic [5:0] r_quads_per_line;
    logic [7:0] r_line_end_char;
    logic       w_front_valid;
    logic       w_front_ready;
    t_job       w_front_job;
    logic       w_back_valid;
    logic       w_back_ready;
    t_job       w_back_job;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quads_per_line <= C_RST_QUADS_PER_LINE;
            r_line_end_char  <= C_RST_LINE_END_CHAR;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_QUADS_PER_LINE: r_quads_per_line <= i_cfg_wdata[5:0];
                CFG_LINE_END_CHAR:  r_line_end_char  <= i_cfg_wdata;
            endcase
        end
    end

    // Item classification and encoder state.
    b64e_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_quads_per_line (r_quads_per_line),
        .i_line_end_char  (r_line_end_char),
        .i_in_valid       (i_in.valid),
        .o_in_ready       (i_in.ready),
        .i_mode           (i_in.mode),
        .i_data_byte      (i_in.data_byte),
        .o_job_valid      (w_front_valid),
        .o_job            (w_front_job),
        .i_job_ready      (w_front_ready)
    );

    // Job queue.
    b64e_fifo #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (w_front_valid),
        .o_in_ready  (w_front_ready),
        .i_in_job    (w_front_job),
        .o_out_valid (w_back_valid),
        .i_out_ready (w_back_ready),
        .o_out_job   (w_back_job)
    );

    // Character sequencer and output register.
    b64e_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (w_back_valid),
        .o_job_ready   (w_back_ready),
        .i_job         (w_back_job),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_out_char    (o_out.out_char),
        .o_last_of_run (o_out.last_of_run)
    );

endmodule

[sim/base64_encoder_line_wrapped_tb.sv]
// Self-checking testbench for the line-wrapped base64 encoder.
`timescale 1ns / 100ps

module base64_encoder_line_wrapped_tb;
    import b64e_pkg::*;

    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    // One expected character on the output channel.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_exp;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic [0:0] i_cfg_index;
    logic [7:0] i_cfg_wdata;

    b64e_in_if  in_ch ();
    b64e_out_if out_ch ();

    base64_encoder_line_wrapped dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #2 i_clk = ~i_clk;

    // Encoder state and register copies, starting at their reset values.
    t_phase     enc_phase      = PH_ZERO;
    logic [3:0] enc_carry      = 4'd0;
    logic [5:0] enc_groups     = 6'd0;
    logic [5:0] enc_quads      = C_RST_QUADS_PER_LINE;
    logic [7:0] enc_line_end   = C_RST_LINE_END_CHAR;

    t_char_exp  pending_chars[$];
    t_char_exp  oldest_char;

    int error_count   = 0;
    int items_sent    = 0;
    int chars_checked = 0;
    int line_ends     = 0;
    int input_stalls  = 0;
    int quiet_cycles  = 0;

    bit no_gaps  = 1'b0;
    bit hold_req = 1'b0;
    bit holding  = 1'b0;

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Standard base64 alphabet lookup.
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        string alphabet;
        alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        return alphabet[v];
    endfunction

    // Work out the characters caused by one item and queue them as expected.
    function automatic void encode_item(input logic mode, input logic [7:0] b);
        logic [7:0] chars[$];
        logic       line_open;
        t_char_exp  e;
        if (mode == MODE_DATA) begin
            case (enc_phase)
                PH_ONE: begin
                    chars.push_back(b64_char({enc_carry[1:0], b[7:4]}));
                    enc_carry = b[3:0];
                    enc_phase = PH_TWO;
                end
                PH_TWO: begin
                    chars.push_back(b64_char({enc_carry, b[7:6]}));
                    chars.push_back(b64_char(b[5:0]));
                    enc_groups = enc_groups + 6'd1;
                    if (enc_groups == enc_quads) begin
                        chars.push_back(enc_line_end);
                        line_ends++;
                        enc_groups = 6'd0;
                    end
                    enc_carry = 4'd0;
                    enc_phase = PH_ZERO;
                end
                default: begin
                    chars.push_back(b64_char(b[7:2]));
                    enc_carry = {2'b00, b[1:0]};
                    enc_phase = PH_ONE;
                end
            endcase
        end else begin
            // End of message: pad out a partial group and close an open line.
            line_open = (enc_groups != 6'd0);
            if (enc_phase == PH_ONE) begin
                chars.push_back(b64_char({enc_carry[1:0], 4'd0}));
                chars.push_back(C_PAD_CHAR);
                chars.push_back(C_PAD_CHAR);
                line_open = 1'b1;
            end else if (enc_phase == PH_TWO) begin
                chars.push_back(b64_char({enc_carry, 2'd0}));
                chars.push_back(C_PAD_CHAR);
                line_open = 1'b1;
            end
            if (line_open) begin
                chars.push_back(enc_line_end);
                line_ends++;
            end
            enc_phase  = PH_ZERO;
            enc_carry  = 4'd0;
            enc_groups = 6'd0;
        end
        foreach (chars[i]) begin
            e.ch   = chars[i];
            e.last = (i == chars.size() - 1);
            pending_chars.push_back(e);
        end
    endfunction

    // Predict on every input transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            encode_item(in_ch.mode, in_ch.data_byte);
            items_sent++;
        end
        if (i_rst_n && in_ch.valid && !in_ch.ready) begin
            input_stalls++;
        end
    end

    // Compare every output transfer with the oldest expected character.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected character, expected none, got %h last %b",
                         $time, out_ch.out_char, out_ch.last_of_run);
                error_count++;
            end else begin
                oldest_char = pending_chars.pop_front();
                chars_checked++;
                if (out_ch.out_char !== oldest_char.ch) begin
                    $display("%0t: out_char expected %h, got %h",
                             $time, oldest_char.ch, out_ch.out_char);
                    error_count++;
                end
                if (out_ch.last_of_run !== oldest_char.last) begin
                    $display("%0t: last_of_run expected %b, got %b",
                             $time, oldest_char.last, out_ch.last_of_run);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d characters outstanding",
                     $time, pending_chars.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin : sink_driver
        int n;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                holding  = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holding = 1'b0;
            end else begin
                n = pick_gap();
                if (n == 0) begin
                    out_ch.ready <= 1'b1;
                    @(posedge i_clk);
                end else begin
                    out_ch.ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
            end
        end
    end

    // Offer one item after a random gap and wait for its transfer.
    task automatic send_item(input logic mode, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= mode;
        in_ch.data_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Send a message of random bytes, closed by a flush with a random byte.
    task automatic send_message(input int len);
        repeat (len) send_item(MODE_DATA, 8'($urandom));
        send_item(MODE_FLUSH, 8'($urandom));
    endtask

    // Stop offering items and wait until every expected character has left.
    task automatic drain_block();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Register write while the block is idle.
    task automatic write_register(input logic [0:0] idx, input logic [7:0] val);
        drain_block();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_QUADS_PER_LINE) begin
            enc_quads = val[5:0];
        end else begin
            enc_line_end = val;
        end
    endtask

    // Default registers: extreme bytes, both special characters and every flush phase.
    task automatic test_defaults();
        send_item(MODE_FLUSH, 8'hFF);
        send_item(MODE_DATA, 8'h00);
        send_item(MODE_DATA, 8'h00);
        send_item(MODE_DATA, 8'h00);
        send_item(MODE_DATA, 8'hFB);
        send_item(MODE_DATA, 8'hEF);
        send_item(MODE_DATA, 8'hBE);
        send_item(MODE_FLUSH, 8'h00);
        send_item(MODE_DATA, 8'hFF);
        send_item(MODE_FLUSH, 8'hA5);
        send_item(MODE_DATA, 8'h00);
        send_item(MODE_DATA, 8'hFF);
        send_item(MODE_FLUSH, 8'h00);
    endtask

    // Shortest and longest lines with the extreme line end bytes.
    task automatic test_line_extremes();
        write_register(CFG_QUADS_PER_LINE, 8'd1);
        write_register(CFG_LINE_END_CHAR, 8'h00);
        repeat (6) send_item(MODE_DATA, 8'($urandom));
        send_item(MODE_FLUSH, 8'h5A);
        send_message(1);
        write_register(CFG_QUADS_PER_LINE, 8'd63);
        write_register(CFG_LINE_END_CHAR, 8'hFF);
        send_message(3);
    endtask

    // Lower the group count below the line position mid-message, to zero, so
    // the only line end before the flush comes when the counter wraps past 63.
    task automatic test_counter_wrap();
        write_register(CFG_QUADS_PER_LINE, 8'd4);
        write_register(CFG_LINE_END_CHAR, 8'($urandom));
        repeat (9) send_item(MODE_DATA, 8'($urandom));
        write_register(CFG_QUADS_PER_LINE, 8'd0);
        send_message(185);
    endtask

    // Short messages under random settings, with stray flushes as noise.
    task automatic test_random_messages();
        for (int c = 0; c < 4; c++) begin
            write_register(CFG_QUADS_PER_LINE, 8'($urandom_range(1, 4)));
            write_register(CFG_LINE_END_CHAR, 8'($urandom));
            no_gaps = (c == 2);
            repeat (2) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_item(MODE_FLUSH, 8'($urandom));
                end
                send_message($urandom_range(0, 4));
            end
        end
        no_gaps = 1'b0;
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls.
    task automatic test_backpressure();
        write_register(CFG_QUADS_PER_LINE, 8'd2);
        hold_req = 1'b1;
        while (!holding) @(posedge i_clk);
        no_gaps = 1'b1;
        send_message(10);
        no_gaps = 1'b0;
    endtask

    initial begin
        in_ch.valid     <= 1'b0;
        in_ch.mode      <= MODE_DATA;
        in_ch.data_byte <= 8'h00;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_index     <= CFG_QUADS_PER_LINE;
        i_cfg_wdata     <= 8'h00;
        i_rst_n         <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_line_extremes();
        test_counter_wrap();
        test_random_messages();
        test_backpressure();
        drain_block();

        $display("Sent %0d items, checked %0d characters including %0d line ends.",
                 items_sent, chars_checked, line_ends);
        $display("Lines of 1 to 64 groups; input held back for %0d cycles.", input_stalls);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
